@@ src/kpl_pkg.sv @@
// Package for the keypad PIN lock controller.
// Holds channel payload types, register indexes, phase codes and reset defaults.
// No dependencies.
`timescale 1ns / 1ps

package kpl_pkg;

   localparam int PIN_DIGITS_DEFAULT = 4;
   localparam int KEY_COUNT          = 20;
   localparam int DIGIT_W            = 5;
   localparam int PIN_WORD_DIGITS    = 4;
   localparam int PIN_WORD_W         = DIGIT_W * PIN_WORD_DIGITS;
   localparam int CHECK_W            = 8;
   localparam int HOLD_W             = 16;
   localparam int RELOCK_W           = 32;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 32;

   localparam logic [CHECK_W-1:0]  CHECK_SEED          = 8'hA5;
   localparam logic [HOLD_W-1:0]   SUCCESS_HOLD_RESET  = 16'd500;
   localparam logic [HOLD_W-1:0]   FAILURE_HOLD_RESET  = 16'd420;
   localparam logic [RELOCK_W-1:0] AUTOLOCK_RESET      = 32'd7200000;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_PIN_WORD     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIN_CHECK    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUCCESS_HOLD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAILURE_HOLD = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTOLOCK     = 3'd4;

   // entry phase codes as seen on the result channel
   localparam logic [1:0] ENTRY_READY   = 2'd0;
   localparam logic [1:0] ENTRY_FAILURE = 2'd1;
   localparam logic [1:0] ENTRY_SUCCESS = 2'd2;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [2:0] {
      PHASE_READY   = 3'b001,
      PHASE_FAILURE = 3'b010,
      PHASE_SUCCESS = 3'b100
   } phase_type;

   typedef struct packed {
      logic               operation;
      logic [DIGIT_W-1:0] key_number;
   } req_type;

   typedef struct packed {
      logic       locked;
      logic [1:0] entry_phase;
      logic [2:0] digits_entered;
      logic       digit_taken;
      logic       unlocked_now;
      logic       rejected_now;
      logic       success_done;
      logic       failure_done;
      logic       autolocked_now;
   } rsp_type;

   // digit i of the stored PIN; digits past the stored word read as zero
   function automatic logic [DIGIT_W-1:0] stored_digit(input logic [PIN_WORD_W-1:0] word,
                                                        input int idx);
      logic [DIGIT_W-1:0] d;
      d = '0;
      if (idx < PIN_WORD_DIGITS) begin
         d = word[idx*DIGIT_W +: DIGIT_W];
      end
      return d;
   endfunction

   function automatic logic [1:0] phase_code(input phase_type p);
      logic [1:0] c;
      unique case (p)
         PHASE_READY:   c = ENTRY_READY;
         PHASE_FAILURE: c = ENTRY_FAILURE;
         PHASE_SUCCESS: c = ENTRY_SUCCESS;
         default:       c = ENTRY_READY;
      endcase
      return c;
   endfunction

endpackage

@@ src/keypad_pin_lock_controller_core.sv @@
// Keypad PIN lock controller: collects key digits, checks them against the stored PIN,
// runs success/failure holds and the auto-lock timeout. Depends on kpl_pkg.
// Requests are registered in s1, then in the rsp register while rsp is not stalled.
// One transaction per cycle unless stalled; lock state is updated in the result stage.
// Reset (synchronous, active high): locked, phase ready, counters and timers cleared,
// registers back to defaults; the entered digit store is not cleared.
`timescale 1ns / 1ps

module keypad_pin_lock_controller_core #(
   parameter int PIN_DIGITS = kpl_pkg::PIN_DIGITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  kpl_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output kpl_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kpl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kpl_pkg::CSR_DATA_W-1:0]      csr_data
);
   import kpl_pkg::*;

   localparam int CNT_W = $clog2(PIN_DIGITS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PIN_DIGITS);

   // configuration
   logic [PIN_WORD_W-1:0] pin_word_ff;
   logic [CHECK_W-1:0]    pin_check_ff;
   logic [HOLD_W-1:0]     success_hold_ff;
   logic [HOLD_W-1:0]     failure_hold_ff;
   logic [RELOCK_W-1:0]   autolock_ff;

   // lock state
   logic                  lock_ff,         lock_in;
   phase_type             phase_ff,        phase_in;
   logic [CNT_W-1:0]      count_ff,        count_in;
   logic [HOLD_W-1:0]     phase_elapsed_ff, phase_elapsed_in;
   logic [RELOCK_W-1:0]   relock_elapsed_ff, relock_elapsed_in;
   logic                  armed_ff,        armed_in;
   logic [DIGIT_W-1:0]    entered_ff [PIN_DIGITS];

   // pipeline
   logic                  s1_valid_ff;
   req_type               s1_data_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff,     rsp_data_in;
   logic                  advance;
   logic                  fire;
   logic                  take;

   logic                  record_ok;
   logic                  entry_ok;
   logic [CNT_W+2:0]      count_wide;

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_word_ff     <= '0;
         pin_check_ff    <= '0;
         success_hold_ff <= SUCCESS_HOLD_RESET;
         failure_hold_ff <= FAILURE_HOLD_RESET;
         autolock_ff     <= AUTOLOCK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PIN_WORD:     pin_word_ff     <= csr_data[PIN_WORD_W-1:0];
            CSR_PIN_CHECK:    pin_check_ff    <= csr_data[CHECK_W-1:0];
            CSR_SUCCESS_HOLD: success_hold_ff <= csr_data[HOLD_W-1:0];
            CSR_FAILURE_HOLD: failure_hold_ff <= csr_data[HOLD_W-1:0];
            CSR_AUTOLOCK:     autolock_ff     <= csr_data[RELOCK_W-1:0];
            default: ;
         endcase
      end
   end

   // stored PIN validity: digit range plus rotate-xor checksum
   always_comb begin
      logic [CHECK_W-1:0] sum;
      logic [DIGIT_W-1:0] d;
      record_ok = 1'b1;
      sum       = CHECK_SEED;
      for (int i = 0; i < PIN_DIGITS; i++) begin
         d = stored_digit(pin_word_ff, i);
         if (d == '0 || d > DIGIT_W'(KEY_COUNT)) begin
            record_ok = 1'b0;
         end
         sum = {sum[CHECK_W-2:0], sum[CHECK_W-1]} ^ {{(CHECK_W-DIGIT_W){1'b0}}, d};
      end
      if (sum != pin_check_ff) begin
         record_ok = 1'b0;
      end
   end

   assign take = (s1_data_ff.operation == OP_KEY) && lock_ff && (phase_ff == PHASE_READY)
                 && (s1_data_ff.key_number != '0)
                 && (s1_data_ff.key_number <= DIGIT_W'(KEY_COUNT))
                 && (count_ff < CNT_FULL);

   // compare with the new key placed at the current count
   always_comb begin
      logic [DIGIT_W-1:0] e;
      entry_ok = record_ok;
      for (int i = 0; i < PIN_DIGITS; i++) begin
         e = (count_ff == CNT_W'(i)) ? s1_data_ff.key_number : entered_ff[i];
         if (e != stored_digit(pin_word_ff, i)) begin
            entry_ok = 1'b0;
         end
      end
   end

   always_comb begin
      lock_in           = lock_ff;
      phase_in          = phase_ff;
      count_in          = count_ff;
      phase_elapsed_in  = phase_elapsed_ff;
      relock_elapsed_in = relock_elapsed_ff;
      armed_in          = armed_ff;
      rsp_data_in       = '0;

      if (s1_data_ff.operation == OP_KEY) begin
         if (take) begin
            count_in                = count_ff + 1'b1;
            rsp_data_in.digit_taken = 1'b1;
            if (count_in == CNT_FULL) begin
               phase_elapsed_in = '0;
               if (entry_ok) begin
                  lock_in                  = 1'b0;
                  phase_in                 = PHASE_SUCCESS;
                  relock_elapsed_in        = '0;
                  armed_in                 = 1'b1;
                  rsp_data_in.unlocked_now = 1'b1;
               end else begin
                  phase_in                 = PHASE_FAILURE;
                  rsp_data_in.rejected_now = 1'b1;
               end
            end
         end
      end else begin
         if (phase_ff != PHASE_READY) begin
            if (phase_elapsed_ff != '1) begin
               phase_elapsed_in = phase_elapsed_ff + 1'b1;
            end
            if (phase_ff == PHASE_SUCCESS && phase_elapsed_in >= success_hold_ff) begin
               phase_in                 = PHASE_READY;
               rsp_data_in.success_done = 1'b1;
            end else if (phase_ff == PHASE_FAILURE && phase_elapsed_in >= failure_hold_ff) begin
               phase_in                 = PHASE_READY;
               count_in                 = '0;
               rsp_data_in.failure_done = 1'b1;
            end
         end
         if (!lock_ff && armed_ff) begin
            if (relock_elapsed_ff != '1) begin
               relock_elapsed_in = relock_elapsed_ff + 1'b1;
            end
            if (relock_elapsed_in >= autolock_ff) begin
               lock_in                    = 1'b1;
               armed_in                   = 1'b0;
               count_in                   = '0;
               phase_in                   = PHASE_READY;
               rsp_data_in.autolocked_now = 1'b1;
            end
         end
      end

      count_wide                 = {3'b000, count_in};
      rsp_data_in.locked         = lock_in;
      rsp_data_in.entry_phase    = phase_code(phase_in);
      rsp_data_in.digits_entered = count_wide[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         lock_ff           <= 1'b1;
         phase_ff          <= PHASE_READY;
         count_ff          <= '0;
         phase_elapsed_ff  <= '0;
         relock_elapsed_ff <= '0;
         armed_ff          <= 1'b0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (fire) begin
            lock_ff           <= lock_in;
            phase_ff          <= phase_in;
            count_ff          <= count_in;
            phase_elapsed_ff  <= phase_elapsed_in;
            relock_elapsed_ff <= relock_elapsed_in;
            armed_ff          <= armed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
      for (int i = 0; i < PIN_DIGITS; i++) begin
         if (fire && take && count_ff == CNT_W'(i)) begin
            entered_ff[i] <= s1_data_ff.key_number;
         end
      end
   end

endmodule
